FILE: hdl/dpwp_pkg.sv
`default_nettype none

package dpwp_pkg;

  // Image geometry defaults
  localparam int unsigned ImgWidthDef   = 512;
  localparam int unsigned ImgHeightDef  = 512;
  localparam int unsigned NumCamerasDef = 4;

  // Word field widths
  localparam int unsigned CamW    = 2;
  localparam int unsigned PixW    = 9;
  localparam int unsigned DepthW  = 16;
  localparam int unsigned IdxW    = 21;
  localparam int unsigned CoordW  = 32;

  // Config port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Datapath widths
  localparam int unsigned DiffW  = 17;  // (u << 4) - center
  localparam int unsigned ProdW  = 34;  // diff * depth
  localparam int unsigned PloW   = 51;  // prod * low half of scale
  localparam int unsigned PhiW   = 50;  // prod * high half of scale
  localparam int unsigned SumW   = 67;  // recombined scale product
  localparam int unsigned XW     = 41;  // camera-frame coordinate, Q.4
  localparam int unsigned CoefW  = 17;  // rotation coefficient, one spare bit for negation
  localparam int unsigned TermW  = 58;  // coefficient * coordinate
  localparam int unsigned AccW   = 61;  // row accumulator, Q.18
  localparam int unsigned ShW    = AccW - 14;

  typedef enum logic [CfgIdxW-1:0] {
    RegScaleU  = 3'd0,
    RegScaleV  = 3'd1,
    RegCenterU = 3'd2,
    RegCenterV = 3'd3,
    RegRowX    = 3'd4,
    RegRowY    = 3'd5,
    RegRowZ    = 3'd6
  } reg_idx_e;

  // Reset values: unit scale, zero center, identity transform
  localparam logic [31:0] ScaleRst  = 32'h0100_0000;
  localparam logic [15:0] CenterRst = 16'h0000;
  localparam logic [63:0] RowXRst   = 64'h0000_0000_0000_4000;
  localparam logic [63:0] RowYRst   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] RowZRst   = 64'h0000_4000_0000_0000;

endpackage

`default_nettype wire

FILE: hdl/dpwp_pixel_if.sv
`default_nettype none

interface dpwp_pixel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  camera;
  logic [8:0]  column;
  logic [8:0]  row;
  logic [15:0] depth;

  modport source (output valid, output camera, output column, output row, output depth,
                  input ready);
  modport sink   (input valid, input camera, input column, input row, input depth,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/dpwp_point_if.sv
`default_nettype none

interface dpwp_point_if;
  logic               valid;
  logic               ready;
  logic [20:0]        point_index;
  logic               point_valid;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_index, output point_valid,
                  output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_index, input point_valid,
                  input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

FILE: hdl/depth_pixel_to_world_point_core.sv
`default_nettype none

// Depth pixel to world point, fully pipelined.
// pix_i takes one depth pixel word (camera, column, row, depth) per cycle while ready;
// pt_o gives one point word per pixel, in order: cloud slot, valid flag and
// x/y/z in Q.4, saturated to 32 bits. Zero depth or a pixel outside the
// configured geometry gives an all-zero word for junk slot 0.
// Throughput: one word per clock while pt_o is not stalled.
// Pipe: six register stages plus the output register, which stage 6
// feeds.
// Stall: the whole pipe moves on one enable; pix_i.ready is high while the
// output register is empty or being taken, so a stalled receiver freezes
// every stage and nothing is dropped or repeated.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write the scale, center and
// transform rows; write only while the pipe is empty. Unknown indices are
// ignored.
// Reset (rst_ni low, async): all stage valids clear, the registers return
// to unit scale, zero center and the identity transform.
module depth_pixel_to_world_point_core #(
  parameter int unsigned IMG_WIDTH   = dpwp_pkg::ImgWidthDef,
  parameter int unsigned IMG_HEIGHT  = dpwp_pkg::ImgHeightDef,
  parameter int unsigned NUM_CAMERAS = dpwp_pkg::NumCamerasDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dpwp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dpwp_pkg::CfgDataW-1:0] cfg_data_i,
  dpwp_pixel_if.sink                         pix_i,
  dpwp_point_if.source                       pt_o
);
  import dpwp_pkg::*;

  localparam logic [31:0] PixPerCam = 32'(IMG_WIDTH * IMG_HEIGHT);

  // ---------------- config registers ----------------
  logic [31:0] scale_u_q, scale_v_q;
  logic [15:0] center_u_q, center_v_q;
  logic [63:0] row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_u_q  <= ScaleRst;
      scale_v_q  <= ScaleRst;
      center_u_q <= CenterRst;
      center_v_q <= CenterRst;
      row_q[0]   <= RowXRst;
      row_q[1]   <= RowYRst;
      row_q[2]   <= RowZRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegScaleU:  scale_u_q  <= cfg_data_i[31:0];
        RegScaleV:  scale_v_q  <= cfg_data_i[31:0];
        RegCenterU: center_u_q <= cfg_data_i[15:0];
        RegCenterV: center_v_q <= cfg_data_i[15:0];
        RegRowX:    row_q[0]   <= cfg_data_i;
        RegRowY:    row_q[1]   <= cfg_data_i;
        RegRowZ:    row_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Static config decode. Coefficient for y is negated here, so the
  // datapath carries the unnegated y and never needs its own negate.
  logic signed [CoefW-1:0] coef [3][3];
  logic signed [15:0]      trans [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = CoefW'($signed(row_q[r][15:0]));
      coef[r][1] = -CoefW'($signed(row_q[r][31:16]));
      coef[r][2] = CoefW'($signed(row_q[r][47:32]));
      trans[r]   = $signed(row_q[r][63:48]);
    end
  end

  // ---------------- pipeline control ----------------
  logic       out_vld_q;
  logic       adv;
  logic [6:1] vld_q;   // stage valids, stage 6 feeds the output register
  logic       acc_in;

  assign adv         = !out_vld_q || pt_o.ready;
  assign pix_i.ready = adv;
  assign acc_in      = pix_i.valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[5:1], acc_in};
      out_vld_q <= vld_q[6];
    end
  end

  // ---------------- stage 1: center offsets, slot, range check ----------------
  logic signed [DiffW-1:0] du_d, dv_d;
  logic                    ok_d;
  logic [31:0]             slot_d;

  always_comb begin
    du_d = DiffW'($signed({1'b0, pix_i.column, 4'b0000})) - DiffW'($signed(center_u_q));
    dv_d = DiffW'($signed({1'b0, pix_i.row, 4'b0000}))    - DiffW'($signed(center_v_q));
    ok_d = (pix_i.depth != '0) && (32'(pix_i.camera) < 32'(NUM_CAMERAS))
        && (32'(pix_i.column) < 32'(IMG_WIDTH)) && (32'(pix_i.row) < 32'(IMG_HEIGHT));
    slot_d = 32'(pix_i.camera) * PixPerCam + 32'(pix_i.row) * 32'(IMG_WIDTH)
           + 32'(pix_i.column) + 32'd1;
  end

  logic signed [DiffW-1:0] s1_du_q, s1_dv_q;
  logic [DepthW-1:0]       dep_q [1:4];
  logic                    ok_q  [1:6];
  logic [IdxW-1:0]         slot_q[1:6];

  // stage 2: depth products
  logic signed [ProdW-1:0] s2_ax_q, s2_ay_q;
  // stage 3: split scale products
  logic signed [PloW-1:0]  s3_lx_q, s3_ly_q;
  logic signed [PhiW-1:0]  s3_hx_q, s3_hy_q;
  // stage 4: camera-frame coordinates
  logic signed [XW-1:0]    s4_x_q, s4_y_q;
  // stage 5: rotation terms
  logic signed [TermW-1:0] s5_t_q [3][3];
  // stage 6: row sums, Q.18
  logic signed [AccW-1:0]  s6_acc_q [3];
  // output
  logic [IdxW-1:0]         o_idx_q;
  logic                    o_ok_q;
  logic signed [CoordW-1:0] o_c_q [3];

  // ---------------- stage 4 combine: round(a * s / 2^24) ----------------
  logic signed [SumW-1:0] sum_x, sum_y;
  logic signed [SumW-1:0] sh_x, sh_y;
  always_comb begin
    sum_x = (SumW'(s3_hx_q) <<< 16) + SumW'(s3_lx_q) + SumW'(25'sh80_0000);
    sum_y = (SumW'(s3_hy_q) <<< 16) + SumW'(s3_ly_q) + SumW'(25'sh80_0000);
    sh_x  = sum_x >>> 24;
    sh_y  = sum_y >>> 24;
  end

  // ---------------- stage 6 sum and output saturate ----------------
  logic signed [AccW-1:0]   acc_d [3];
  logic signed [ShW-1:0]    rnd   [3];
  logic signed [CoordW-1:0] sat_d [3];
  logic signed [XW-1:0]     zq;
  always_comb begin
    zq = $signed({{(XW-DepthW-4){1'b0}}, dep_q[4], 4'b0000});
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = AccW'(s5_t_q[r][0]) + AccW'(s5_t_q[r][1]) + AccW'(s5_t_q[r][2])
               + (AccW'(trans[r]) <<< 18) + AccW'(15'sh2000);
      rnd[r]   = ShW'(s6_acc_q[r] >>> 14);
      if (rnd[r] > ShW'(32'sh7FFF_FFFF)) begin
        sat_d[r] = 32'sh7FFF_FFFF;
      end else if (rnd[r] < ShW'(-33'sh8000_0000)) begin
        sat_d[r] = -32'sh8000_0000;
      end else begin
        sat_d[r] = CoordW'(rnd[r]);
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      s1_du_q   <= du_d;
      s1_dv_q   <= dv_d;
      dep_q[1]  <= pix_i.depth;
      ok_q[1]   <= ok_d;
      slot_q[1] <= slot_d[IdxW-1:0];
      // stage 2
      s2_ax_q   <= ProdW'(s1_du_q) * ProdW'($signed({1'b0, dep_q[1]}));
      s2_ay_q   <= ProdW'(s1_dv_q) * ProdW'($signed({1'b0, dep_q[1]}));
      // stage 3
      s3_lx_q   <= PloW'(s2_ax_q) * PloW'($signed({1'b0, scale_u_q[15:0]}));
      s3_ly_q   <= PloW'(s2_ay_q) * PloW'($signed({1'b0, scale_v_q[15:0]}));
      s3_hx_q   <= PhiW'(s2_ax_q) * PhiW'($signed(scale_u_q[31:16]));
      s3_hy_q   <= PhiW'(s2_ay_q) * PhiW'($signed(scale_v_q[31:16]));
      // stage 4
      s4_x_q    <= XW'(sh_x);
      s4_y_q    <= XW'(sh_y);
      // stage 5
      for (int r = 0; r < 3; r++) begin
        s5_t_q[r][0] <= TermW'(coef[r][0]) * TermW'(s4_x_q);
        s5_t_q[r][1] <= TermW'(coef[r][1]) * TermW'(s4_y_q);
        s5_t_q[r][2] <= TermW'(coef[r][2]) * TermW'(zq);
      end
      // stage 6
      for (int r = 0; r < 3; r++) begin
        s6_acc_q[r] <= acc_d[r];
      end
      // sideband
      for (int s = 2; s <= 4; s++) begin
        dep_q[s] <= dep_q[s-1];
      end
      for (int s = 2; s <= 6; s++) begin
        ok_q[s]   <= ok_q[s-1];
        slot_q[s] <= slot_q[s-1];
      end
      // output word, zeroed for junk pixels
      o_ok_q  <= ok_q[6];
      o_idx_q <= ok_q[6] ? slot_q[6] : '0;
      for (int r = 0; r < 3; r++) begin
        o_c_q[r] <= ok_q[6] ? sat_d[r] : '0;
      end
    end
  end

  assign pt_o.valid       = out_vld_q;
  assign pt_o.point_index = o_idx_q;
  assign pt_o.point_valid = o_ok_q;
  assign pt_o.point_x     = o_c_q[0];
  assign pt_o.point_y     = o_c_q[1];
  assign pt_o.point_z     = o_c_q[2];

endmodule

`default_nettype wire

FILE: tb/sv/dpwp_point_checker.sv
`default_nettype none

// Watches the pixel and point channels plus the register port, predicts
// every point word and compares it with what the core puts out.
module dpwp_point_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dpwp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dpwp_pkg::CfgDataW-1:0] cfg_data_i,
  dpwp_pixel_if                              pix,
  dpwp_point_if                              pt,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dpwp_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]          index;
    logic                     valid;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  localparam longint CoordMax = (longint'(1) <<< 31) - 1;
  localparam longint CoordMin = -(longint'(1) <<< 31);

  logic [31:0] scale_u_q, scale_v_q;
  logic [15:0] center_u_q, center_v_q;
  logic [63:0] row_x_q, row_y_q, row_z_q;

  point_t expected_points[$];

  // a * s / 2^24, round half up
  function automatic longint scale_round(longint a, longint s);
    return (a * s + (longint'(1) <<< 23)) >>> 24;
  endfunction

  // One row of rotation plus translation, Q.18 down to Q.4, saturated
  function automatic logic signed [CoordW-1:0] rigid_row(logic [63:0] r, longint x,
                                                         longint y, longint z);
    longint acc;
    longint v;
    acc = longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y +
          longint'($signed(r[47:32])) * z + (longint'($signed(r[63:48])) <<< 18);
    v = (acc + (longint'(1) <<< 13)) >>> 14;
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v[CoordW-1:0];
  endfunction

  function automatic point_t project_pixel(logic [CamW-1:0] cam, logic [PixW-1:0] u,
                                           logic [PixW-1:0] v, logic [DepthW-1:0] d);
    point_t p;
    longint z, du, dv, x, y, slot;
    p = '0;
    if (d == '0 || cam >= NumCamerasDef || u >= ImgWidthDef || v >= ImgHeightDef)
      return p;
    z  = longint'(d);
    du = longint'({u, 4'b0}) - longint'($signed(center_u_q));
    dv = longint'({v, 4'b0}) - longint'($signed(center_v_q));
    x  = scale_round(du * z, longint'($signed(scale_u_q)));
    y  = -scale_round(dv * z, longint'($signed(scale_v_q)));
    slot = longint'(cam) * ImgWidthDef * ImgHeightDef + longint'(v) * ImgWidthDef +
           longint'(u) + 1;
    p.index = slot[IdxW-1:0];
    p.valid = 1'b1;
    p.x = rigid_row(row_x_q, x, y, z <<< 4);
    p.y = rigid_row(row_y_q, x, y, z <<< 4);
    p.z = rigid_row(row_z_q, x, y, z <<< 4);
    return p;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      scale_u_q  = ScaleRst;
      scale_v_q  = ScaleRst;
      center_u_q = CenterRst;
      center_v_q = CenterRst;
      row_x_q    = RowXRst;
      row_y_q    = RowYRst;
      row_z_q    = RowZRst;
      expected_points.delete();
      fail_count = 0;
    end else begin
      if (pix.valid && pix.ready)
        expected_points.push_back(project_pixel(pix.camera, pix.column, pix.row,
                                                pix.depth));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegScaleU:  scale_u_q  = cfg_data_i[31:0];
          RegScaleV:  scale_v_q  = cfg_data_i[31:0];
          RegCenterU: center_u_q = cfg_data_i[15:0];
          RegCenterV: center_v_q = cfg_data_i[15:0];
          RegRowX:    row_x_q    = cfg_data_i;
          RegRowY:    row_y_q    = cfg_data_i;
          RegRowZ:    row_z_q    = cfg_data_i;
          default:    ;
        endcase
      end
      if (pt.valid && pt.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: point word expected none got index %0d", $time,
                   pt.point_index);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_index", want.index, pt.point_index);
          check_field("point_valid", want.valid, pt.point_valid);
          check_field("point_x", want.x, pt.point_x);
          check_field("point_y", want.y, pt.point_y);
          check_field("point_z", want.z, pt.point_z);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/depth_pixel_to_world_point_core_tb.sv
`default_nettype none

// Stimulus and verdict for the depth-pixel back-projection core.
// The checker beside the core does all prediction and comparison.
module depth_pixel_to_world_point_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpwp_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  fail_count;
  int                  pending;
  bit                  calm;   // no idling on either side while set

  dpwp_pixel_if pix ();
  dpwp_point_if pt ();

  depth_pixel_to_world_point_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .pt_o       (pt)
  );

  dpwp_point_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix        (pix),
    .pt         (pt),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Mostly back-to-back, often a few cycles, now and then a long hole.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                           logic [15:0] c2, logic [15:0] t);
    return {t, c2, c1, c0};
  endfunction

  // Realistic scales are small Q8.24 values of either sign; wild ones are anything.
  function automatic logic [31:0] pick_scale(bit wild);
    logic [31:0] mag;
    if (wild) return $urandom;
    mag = $urandom_range(0, 32'h0010_0000);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [15:0] pick_coef(bit wild);
    logic [31:0] c;
    c = wild ? $urandom : $urandom_range(0, 32767) - 16384;
    return c[15:0];
  endfunction

  // Zero depth, full scale and tiny depths show up often on purpose.
  function automatic logic [DepthW-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DepthW'($urandom_range(1, 15));
    return DepthW'($urandom_range(1, 65535));
  endfunction

  // Drop valid, wait for every predicted word to come out, then let the
  // clock run on before returning.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Loads all seven registers back to back, then pokes the unused index.
  // Spare upper data bits carry junk; the core must mask them off.
  task automatic apply_setting(logic [31:0] su, logic [31:0] sv, logic [15:0] cu,
                               logic [15:0] cv, logic [63:0] rx, logic [63:0] ry,
                               logic [63:0] rz);
    logic [63:0] vals [7];
    wait_idle();
    vals[0] = {32'($urandom), su};
    vals[1] = {32'($urandom), sv};
    vals[2] = {48'({$urandom, $urandom}), cu};
    vals[3] = {48'({$urandom, $urandom}), cv};
    vals[4] = rx;
    vals[5] = ry;
    vals[6] = rz;
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_idx_i  <= RegNone;
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pixel word and hold it until taken. Valid stays high across
  // back-to-back words; during a hole the payload carries junk.
  task automatic push_pixel(logic [CamW-1:0] cam, logic [PixW-1:0] col,
                            logic [PixW-1:0] row, logic [DepthW-1:0] depth);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      pix.valid  <= 1'b0;
      pix.camera <= CamW'($urandom);
      pix.column <= PixW'($urandom);
      pix.row    <= PixW'($urandom);
      pix.depth  <= DepthW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    pix.valid  <= 1'b1;
    pix.camera <= cam;
    pix.column <= col;
    pix.row    <= row;
    pix.depth  <= depth;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  // Receiver: holds ready for a short random run, then maybe stalls.
  initial begin
    int gap;
    pt.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        pt.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pt.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    bit wild;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= RegScaleU;
    cfg_data_i <= '0;
    pix.valid  <= 1'b0;
    pix.camera <= '0;
    pix.column <= '0;
    pix.row    <= '0;
    pix.depth  <= '0;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: unit scale, zero center, identity transform.
    // Zero depth, corner pixels, every camera, highest cloud slot.
    push_pixel(0, 0, 0, 0);
    push_pixel(3, 511, 511, 16'hFFFF);
    push_pixel(0, 0, 0, 1);
    push_pixel(1, 256, 128, 1000);
    push_pixel(2, 511, 0, 16'h8000);
    push_pixel(3, 0, 511, 16'hFFFF);
    push_pixel(0, 0, 0, 16'hFFFF);
    push_pixel(2, 100, 200, 0);

    // Extreme registers: largest scales of both signs, center at both ends,
    // coefficients and offsets at their limits -> coordinates saturate.
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF,
                  pack_row(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF),
                  pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                  pack_row(16'h0000, 16'h0000, 16'h0001, 16'hFFFF));
    push_pixel(0, 0, 0, 16'hFFFF);
    push_pixel(3, 511, 511, 16'hFFFF);
    push_pixel(1, 511, 0, 1);
    push_pixel(2, 0, 511, 16'h7FFF);
    push_pixel(0, 0, 0, 0);

    // Smallest scale: du*depth lands exactly on a half step, so the
    // round-half-up rule decides x; the v side rounds the negative half.
    apply_setting(32'd1, 32'd1, 16'h0000, 16'h0200, RowXRst, RowYRst, RowZRst);
    push_pixel(0, 16, 16, 16'h8000);
    push_pixel(1, 16, 17, 16'h8000);
    push_pixel(2, 0, 0, 16'hFFFF);
    push_pixel(3, 511, 511, 16'hFFFF);

    // Random phases: alternate plausible camera setups with arbitrary
    // register contents; two phases run with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      wild = ph[0];
      calm = 1'b0;
      apply_setting(pick_scale(wild), pick_scale(wild),
                    wild ? 16'($urandom) : 16'($urandom_range(0, 8191)),
                    wild ? 16'($urandom) : 16'($urandom_range(0, 8191)),
                    pack_row(pick_coef(wild), pick_coef(wild), pick_coef(wild),
                             16'($urandom)),
                    pack_row(pick_coef(wild), pick_coef(wild), pick_coef(wild),
                             16'($urandom)),
                    pack_row(pick_coef(wild), pick_coef(wild), pick_coef(wild),
                             16'($urandom)));
      calm = (ph == 2) || (ph == 5);
      repeat (160)
        push_pixel(CamW'($urandom_range(0, 3)), PixW'($urandom_range(0, 511)),
                   PixW'($urandom_range(0, 511)), pick_depth());
    end

    calm = 1'b0;
    wait_idle();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
